// ===== rtl/core/dps_pkg.sv =====
`default_nettype none
package dps_pkg;

	// queue entry kinds
	localparam logic KIND_SEG   = 1'b0;
	localparam logic KIND_START = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_VP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_VP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DASH_LEN  = 2'd2;
	localparam logic [1:0] REG_GAP_LEN   = 2'd3;

	localparam int COORD_W = 17;
	localparam int MAG_W   = 17;
	localparam int LEN_W   = 18;
	localparam int PER_W   = 13;
	localparam int CFG_W   = 12;

	// segment or phase-reset command from front to back
	typedef struct packed {
		logic                 kind;
		logic [COORD_W-1:0]   ax;
		logic [COORD_W-1:0]   ay;
		logic                 nx;
		logic                 ny;
		logic [MAG_W-1:0]     mx;
		logic [MAG_W-1:0]     my;
		logic [LEN_W-1:0]     len;
	} dps_seg_t;

	// one dash result
	typedef struct packed {
		logic                 trunc;
		logic                 last;
		logic [COORD_W-1:0]   ey;
		logic [COORD_W-1:0]   ex;
		logic [COORD_W-1:0]   sy;
		logic [COORD_W-1:0]   sx;
	} dps_dash_t;

endpackage
`default_nettype wire

// ===== rtl/core/dps_queue.sv =====
`default_nettype none
module dps_queue
	import dps_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire dps_seg_t push_data,
	output logic          full,
	input  wire logic     pop,
	output logic          valid,
	output dps_seg_t      pop_data
);

	dps_seg_t   mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign full     = (cnt_q == 3'd4);
	assign valid    = (cnt_q != 3'd0);
	assign pop_data = mem_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 2'd1;
			if (pop && valid)
				rd_q <= rd_q + 2'd1;
			case ({push && !full, pop && valid})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dps_front.sv =====
`default_nettype none
module dps_front
	import dps_pkg::*;
#(
	parameter int FRAC_BITS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [COORD_W-1:0]   px,
	input  wire logic [COORD_W-1:0]   py,
	input  wire logic                 pstart,
	input  wire logic [CFG_W-1:0]     vp_w,
	input  wire logic [CFG_W-1:0]     vp_h,
	output logic                      push,
	output dps_seg_t                  push_data,
	input  wire logic                 full
);

	localparam int CMPW0 = CFG_W + FRAC_BITS + 2;
	localparam int CMPW  = (CMPW0 > COORD_W + 1) ? CMPW0 : COORD_W + 1;
	localparam int PAD   = 32 << FRAC_BITS;

	localparam logic [2:0] F_IDLE   = 3'd0;
	localparam logic [2:0] F_CLASS  = 3'd1;
	localparam logic [2:0] F_MUL    = 3'd2;
	localparam logic [2:0] F_ADD    = 3'd3;
	localparam logic [2:0] F_SQRT   = 3'd4;
	localparam logic [2:0] F_PUSH   = 3'd5;
	localparam logic [2:0] F_PSTART = 3'd6;

	logic [2:0]          st_q;
	logic [COORD_W-1:0]  vx_q, vy_q;
	logic                vs_q;
	logic [COORD_W-1:0]  prev_x_q, prev_y_q;
	logic                have_prev_q;
	logic [COORD_W-1:0]  ax_q, ay_q;
	logic                nx_q, ny_q;
	logic [MAG_W-1:0]    mx_q, my_q;
	logic [2*MAG_W-1:0]  sqx_q, sqy_q;
	logic [35:0]         rad_q;
	logic [19:0]         rem_q;
	logic [LEN_W-1:0]    root_q;
	logic [4:0]          it_q;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        adx, ady;
	logic                    in_a, in_b;
	logic [21:0]             rsh, trial;

	function automatic logic inside_pad(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [CFG_W-1:0] w,
		input logic [CFG_W-1:0] h);
		logic signed [CMPW-1:0] xs, ys, hx, hy, lo;
		xs = CMPW'($signed(x));
		ys = CMPW'($signed(y));
		hx = $signed((CMPW'(w) << FRAC_BITS) + CMPW'(PAD));
		hy = $signed((CMPW'(h) << FRAC_BITS) + CMPW'(PAD));
		lo = -$signed(CMPW'(PAD));
		return (xs >= lo) && (xs <= hx) && (ys >= lo) && (ys <= hy);
	endfunction

	// classify against the previous vertex
	always_comb begin
		dx   = $signed({vx_q[COORD_W-1], vx_q}) - $signed({prev_x_q[COORD_W-1], prev_x_q});
		dy   = $signed({vy_q[COORD_W-1], vy_q}) - $signed({prev_y_q[COORD_W-1], prev_y_q});
		adx  = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
		ady  = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
		in_a = inside_pad(prev_x_q, prev_y_q, vp_w, vp_h);
		in_b = inside_pad(vx_q, vy_q, vp_w, vp_h);
	end

	// one root digit per cycle
	assign rsh   = {rem_q, rad_q[35:34]};
	assign trial = {root_q, 2'b01};

	assign in_ready = (st_q == F_IDLE);
	assign push     = (st_q == F_PUSH) || (st_q == F_PSTART);

	always_comb begin
		push_data      = '0;
		push_data.kind = (st_q == F_PSTART) ? KIND_START : KIND_SEG;
		push_data.ax   = ax_q;
		push_data.ay   = ay_q;
		push_data.nx   = nx_q;
		push_data.ny   = ny_q;
		push_data.mx   = mx_q;
		push_data.my   = my_q;
		push_data.len  = root_q;
	end

	// hold the segment datapath
	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				vx_q <= px;
				vy_q <= py;
				vs_q <= pstart;
			end
			F_CLASS: begin
				ax_q <= prev_x_q;
				ay_q <= prev_y_q;
				nx_q <= dx[COORD_W];
				ny_q <= dy[COORD_W];
				mx_q <= adx[MAG_W-1:0];
				my_q <= ady[MAG_W-1:0];
			end
			F_MUL: begin
				sqx_q <= mx_q * mx_q;
				sqy_q <= my_q * my_q;
			end
			F_ADD: begin
				rad_q  <= 36'(sqx_q) + 36'(sqy_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			F_SQRT: begin
				rad_q <= {rad_q[33:0], 2'b00};
				if (rsh >= trial) begin
					rem_q  <= 20'(rsh - trial);
					root_q <= {root_q[LEN_W-2:0], 1'b1};
				end else begin
					rem_q  <= rsh[19:0];
					root_q <= {root_q[LEN_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// sequence the front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= F_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			it_q        <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (in_valid)
						st_q <= F_CLASS;
				end
				F_CLASS: begin
					prev_x_q    <= vx_q;
					prev_y_q    <= vy_q;
					have_prev_q <= 1'b1;
					if (vs_q)
						st_q <= F_PSTART;
					else if (!have_prev_q)
						st_q <= F_IDLE;
					else if (!in_a && !in_b)
						st_q <= F_IDLE;
					else if (dx == '0 && dy == '0)
						st_q <= F_IDLE;
					else
						st_q <= F_MUL;
				end
				F_MUL: st_q <= F_ADD;
				F_ADD: begin
					it_q <= 5'd18;
					st_q <= F_SQRT;
				end
				F_SQRT: begin
					it_q <= it_q - 5'd1;
					if (it_q == 5'd1)
						st_q <= F_PUSH;
				end
				F_PUSH, F_PSTART: begin
					if (!full)
						st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dps_lerp.sv =====
`default_nettype none
module dps_lerp
	import dps_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [COORD_W-1:0]   a,
	input  wire logic                 neg,
	input  wire logic [MAG_W-1:0]     mag,
	input  wire logic [LEN_W-1:0]     t,
	input  wire logic [LEN_W-1:0]     len,
	output logic                      busy,
	output logic [COORD_W-1:0]        res
);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_LOAD = 2'd1;
	localparam logic [1:0] L_DIV  = 2'd2;

	logic [1:0]               st_q;
	logic [COORD_W-1:0]       a_q;
	logic                     neg_q;
	logic [LEN_W-1:0]         len_q;
	logic [MAG_W+LEN_W-1:0]   prod_q;
	logic [18:0]              r_q;
	logic [17:0]              sh_q;
	logic [17:0]              quo_q;
	logic [4:0]               it_q;

	logic [36:0] num;
	logic [19:0] rt, dv;
	logic [18:0] sum_ext;

	// round to nearest: (2*mag*t + len) / (2*len)
	assign num = {1'b0, prod_q, 1'b0} + 37'(len_q);
	assign rt  = {r_q, sh_q[17]};
	assign dv  = {1'b0, len_q, 1'b0};

	assign busy    = (st_q != L_IDLE);
	assign sum_ext = neg_q ? 19'($signed({{2{a_q[COORD_W-1]}}, a_q}) - $signed({1'b0, quo_q}))
	                       : 19'($signed({{2{a_q[COORD_W-1]}}, a_q}) + $signed({1'b0, quo_q}));
	assign res     = sum_ext[COORD_W-1:0];

	// operands, product and restoring division
	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					a_q    <= a;
					neg_q  <= neg;
					len_q  <= len;
					prod_q <= mag * t;
				end
			end
			L_LOAD: begin
				r_q   <= num[36:18];
				sh_q  <= num[17:0];
				quo_q <= '0;
			end
			L_DIV: begin
				sh_q <= {sh_q[16:0], 1'b0};
				if (rt >= dv) begin
					r_q   <= 19'(rt - dv);
					quo_q <= {quo_q[16:0], 1'b1};
				end else begin
					r_q   <= rt[18:0];
					quo_q <= {quo_q[16:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			it_q <= '0;
		end else begin
			case (st_q)
				L_IDLE: if (start) st_q <= L_LOAD;
				L_LOAD: begin
					it_q <= 5'd18;
					st_q <= L_DIV;
				end
				L_DIV: begin
					it_q <= it_q - 5'd1;
					if (it_q == 5'd1)
						st_q <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dps_rem.sv =====
`default_nettype none
module dps_rem
	import dps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [18:0]        dividend,
	input  wire logic [PER_W-1:0]   divisor,
	output logic                    busy,
	output logic [PER_W-1:0]        rem
);

	logic [PER_W-1:0] r_q;
	logic [PER_W-1:0] d_q;
	logic [18:0]      sh_q;
	logic [4:0]       it_q;
	logic [PER_W:0]   rt;

	assign rt   = {r_q, sh_q[18]};
	assign busy = (it_q != 5'd0);
	assign rem  = r_q;

	// one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			r_q  <= '0;
			d_q  <= divisor;
			sh_q <= dividend;
		end else if (busy) begin
			sh_q <= {sh_q[17:0], 1'b0};
			if (rt >= {1'b0, d_q})
				r_q <= PER_W'(rt - {1'b0, d_q});
			else
				r_q <= rt[PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			it_q <= '0;
		else if (start && !busy)
			it_q <= 5'd19;
		else if (busy)
			it_q <= it_q - 5'd1;
	end

endmodule
`default_nettype wire

// ===== rtl/core/dps_back.sv =====
`default_nettype none
module dps_back
	import dps_pkg::*;
#(
	parameter int MAXD = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire dps_seg_t           q_data,
	output logic                    pop,
	input  wire logic [CFG_W-1:0]   dash_len,
	input  wire logic [CFG_W-1:0]   gap_len,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dps_dash_t               out_data
);

	localparam int CNT_W = $clog2(MAXD + 1);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MOD0 = 3'd1;
	localparam logic [2:0] B_WALK = 3'd2;
	localparam logic [2:0] B_LERP = 3'd3;
	localparam logic [2:0] B_FIN  = 3'd4;
	localparam logic [2:0] B_MOD1 = 3'd5;

	logic [2:0]        st_q;
	dps_seg_t          seg_q;
	logic [PER_W-1:0]  per_q, q0_q, q_q, phase_q;
	logic [LEN_W-1:0]  t_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              trunc_q;
	logic              pend_valid_q;
	dps_dash_t         pend_q;

	logic [PER_W-1:0]  per_sum;
	logic              out_free;
	logic              out_load;
	logic              in_dash;
	logic [LEN_W-1:0]  left, span, step, t_end;
	logic [LEN_W:0]    q_next;
	logic              lerp_go;
	logic              rem_go, rem_busy;
	logic [18:0]       rem_arg;
	logic [PER_W-1:0]  rem_val;
	logic [3:0]        l_busy;
	logic [COORD_W-1:0] l_res [4];

	function automatic logic [LEN_W-1:0] len_q_minus_t(input logic [LEN_W-1:0] l,
		input logic [LEN_W-1:0] t);
		return l - t;
	endfunction

	assign per_sum  = PER_W'(dash_len) + PER_W'(gap_len);
	assign out_free = !out_valid || out_ready;
	assign pop      = (st_q == B_IDLE) && q_valid;

	// move the pending dash to the output register
	assign out_load = pend_valid_q && out_free &&
		((st_q == B_LERP && !(|l_busy)) || st_q == B_FIN);

	// size the next step of the walk
	always_comb begin
		in_dash = (q_q < PER_W'(dash_len));
		left    = len_q_minus_t(seg_q.len, t_q);
		span    = in_dash ? LEN_W'(PER_W'(dash_len) - q_q) : LEN_W'(per_q - q_q);
		step    = (span < left) ? span : left;
		t_end   = t_q + step;
		q_next  = (LEN_W+1)'(q_q) + (LEN_W+1)'(step);
	end

	assign lerp_go = (st_q == B_WALK) && (t_q < seg_q.len) && in_dash && (cnt_q != CNT_W'(MAXD));

	// start and end point lanes
	dps_lerp u_lsx (.clk, .arst_n, .start(lerp_go), .a(seg_q.ax), .neg(seg_q.nx),
		.mag(seg_q.mx), .t(t_q), .len(seg_q.len), .busy(l_busy[0]), .res(l_res[0]));
	dps_lerp u_lsy (.clk, .arst_n, .start(lerp_go), .a(seg_q.ay), .neg(seg_q.ny),
		.mag(seg_q.my), .t(t_q), .len(seg_q.len), .busy(l_busy[1]), .res(l_res[1]));
	dps_lerp u_lex (.clk, .arst_n, .start(lerp_go), .a(seg_q.ax), .neg(seg_q.nx),
		.mag(seg_q.mx), .t(t_end), .len(seg_q.len), .busy(l_busy[2]), .res(l_res[2]));
	dps_lerp u_ley (.clk, .arst_n, .start(lerp_go), .a(seg_q.ay), .neg(seg_q.ny),
		.mag(seg_q.my), .t(t_end), .len(seg_q.len), .busy(l_busy[3]), .res(l_res[3]));

	// shared remainder unit for the phase
	always_comb begin
		rem_go  = 1'b0;
		rem_arg = 19'(phase_q);
		if (st_q == B_IDLE && q_valid && q_data.kind == KIND_SEG && per_sum != '0)
			rem_go = 1'b1;
		if (st_q == B_FIN && (!pend_valid_q || out_free)) begin
			rem_go  = 1'b1;
			rem_arg = 19'(q0_q) + 19'(seg_q.len);
		end
	end

	dps_rem u_rem (.clk, .arst_n, .start(rem_go), .dividend(rem_arg),
		.divisor(st_q == B_IDLE ? per_sum : per_q), .busy(rem_busy), .rem(rem_val));

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			seg_q <= q_data;
		if (st_q == B_IDLE)
			per_q <= per_sum;
		if (st_q == B_MOD0 && !rem_busy) begin
			q_q  <= rem_val;
			q0_q <= rem_val;
			t_q  <= '0;
		end
		if (st_q == B_WALK && t_q < seg_q.len && !(in_dash && cnt_q == CNT_W'(MAXD))) begin
			t_q <= t_end;
			q_q <= (q_next == (LEN_W+1)'(per_q)) ? '0 : q_next[PER_W-1:0];
		end
		if (st_q == B_LERP && !(|l_busy) && (!pend_valid_q || out_free)) begin
			pend_q.sx    <= l_res[0];
			pend_q.sy    <= l_res[1];
			pend_q.ex    <= l_res[2];
			pend_q.ey    <= l_res[3];
			pend_q.last  <= 1'b0;
			pend_q.trunc <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (st_q == B_LERP && !(|l_busy) && pend_valid_q && out_free)
			out_data <= pend_q;
		else if (st_q == B_FIN && pend_valid_q && out_free)
			out_data <= {trunc_q, 1'b1, pend_q.ey, pend_q.ex, pend_q.sy, pend_q.sx};
	end

	// sequence the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			phase_q      <= '0;
			cnt_q        <= '0;
			trunc_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_data.kind == KIND_START)
							phase_q <= '0;
						else if (per_sum == '0)
							phase_q <= '0;
						else
							st_q <= B_MOD0;
					end
				end
				B_MOD0: begin
					cnt_q   <= '0;
					trunc_q <= 1'b0;
					if (!rem_busy)
						st_q <= B_WALK;
				end
				B_WALK: begin
					if (t_q >= seg_q.len)
						st_q <= B_FIN;
					else if (in_dash) begin
						if (cnt_q == CNT_W'(MAXD)) begin
							trunc_q <= 1'b1;
							st_q    <= B_FIN;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
							st_q  <= B_LERP;
						end
					end
				end
				B_LERP: begin
					if (!(|l_busy) && (!pend_valid_q || out_free)) begin
						pend_valid_q <= 1'b1;
						st_q         <= B_WALK;
					end
				end
				B_FIN: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b0;
						st_q         <= B_MOD1;
					end
				end
				B_MOD1: begin
					if (!rem_busy) begin
						phase_q <= rem_val;
						st_q    <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dashed_polyline_splitter.sv =====
// A lone dash leaves once the front has formed the squares and an 18-step root and the
// back has run the phase remainder, the dash's interpolation and the close of the segment;
// a dash that another follows is held until its last flag is known.
// The front takes one vertex at a time and accepts no new vertex until it is done with the
// last; the back works out each dash with four 18-step dividers in parallel. Reset: arst_n
// clears control state, the vertex history, the phase and the queue, and loads the
// configuration defaults.
`default_nettype none
module dashed_polyline_splitter
	import dps_pkg::*;
#(
	parameter int MAX_DASHES          = 64,
	parameter int COORD_FRACTION_BITS = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [39:0]   s_tdata,   // point_x, point_y, zero fill
	input  wire logic          s_tuser,   // starts_polyline
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [71:0]        m_tdata,   // dash_start_x, dash_start_y, dash_end_x, dash_end_y, zero fill
	output logic               m_tlast,
	output logic               m_tuser,   // truncated
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [11:0]   cfg_data
);

	logic [CFG_W-1:0] vp_w_q, vp_h_q, dash_q, gap_q;
	logic             push, full, q_valid, pop;
	dps_seg_t         push_data, q_data;
	dps_dash_t        res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= 12'd1024;
			vp_h_q <= 12'd768;
			dash_q <= 12'd80;
			gap_q  <= 12'd80;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VP_WIDTH:  vp_w_q <= cfg_data;
				REG_VP_HEIGHT: vp_h_q <= cfg_data;
				REG_DASH_LEN:  dash_q <= cfg_data;
				REG_GAP_LEN:   gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dps_front #(.FRAC_BITS(COORD_FRACTION_BITS)) u_front (
		.clk, .arst_n,
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.px       (s_tdata[16:0]),
		.py       (s_tdata[33:17]),
		.pstart   (s_tuser),
		.vp_w     (vp_w_q),
		.vp_h     (vp_h_q),
		.push, .push_data, .full
	);

	dps_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full,
		.pop, .valid(q_valid), .pop_data(q_data)
	);

	dps_back #(.MAXD(MAX_DASHES)) u_back (
		.clk, .arst_n, .q_valid, .q_data, .pop,
		.dash_len  (dash_q),
		.gap_len   (gap_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {4'b0, res.ey, res.ex, res.sy, res.sx};
	assign m_tlast = res.last;
	assign m_tuser = res.trunc;

endmodule
`default_nettype wire

// ===== rtl/core/dps_checker.sv =====
`default_nettype none
module dps_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tvalid,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [71:0]   m_tdata,
	input wire logic          m_tlast,
	input wire logic          m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// truncation only marks the closing dash
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("truncated set on a dash that is not last");

	// one vertex at a time in the front
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("vertex taken while the front is busy");

endmodule

bind dashed_polyline_splitter dps_checker u_dps_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
);
`default_nettype wire
